// ----- sv/fcce_pkg.sv -----
// Shared constants, types and tables for the framed config command engine.
package fcce_pkg;

  localparam int unsigned MaxFrame   = 8;
  localparam int unsigned NumVars    = 7;
  localparam int unsigned StoreDepth = 7;
  localparam int unsigned StoreAw    = 3;
  localparam int unsigned StoreW     = 16;
  localparam int unsigned NumWide    = 3;
  localparam int unsigned HeadBytes  = 3;

  localparam logic [7:0] CodeAck      = 8'hAC;
  localparam logic [7:0] CodeBadCmd   = 8'hE0;
  localparam logic [7:0] CodeBadVar   = 8'hE1;
  localparam logic [7:0] CodeBadParam = 8'hE2;
  localparam logic [7:0] CodeTooLong  = 8'hE4;
  localparam logic [7:0] CodeTimeout  = 8'hE5;
  localparam logic [7:0] CmdFinish    = 8'hFF;
  localparam logic [3:0] OpRead       = 4'h0;
  localparam logic [3:0] OpWrite      = 4'h3;

  typedef enum logic [3:0] {
    PhWait    = 4'b0001,
    PhCollect = 4'b0010,
    PhDrain   = 4'b0100,
    PhDone    = 4'b1000
  } phase_e;

  // power-up values of the setting variables
  function automatic logic [StoreW-1:0] store_default(logic [StoreAw-1:0] idx);
    logic [StoreW-1:0] v;
    case (idx)
      3'd0:    v = 16'h0800;
      3'd3:    v = 16'h00FF;
      3'd4:    v = 16'h0008;
      3'd5:    v = 16'h0005;
      default: v = 16'h0000;
    endcase
    return v;
  endfunction

  // bytes per variable: 16-bit, 8-bit, or no storage
  function automatic logic [1:0] var_width(logic [3:0] idx);
    logic [1:0] w;
    if ({28'd0, idx} < NumWide) w = 2'd2;
    else if ({28'd0, idx} < StoreDepth) w = 2'd1;
    else w = 2'd0;
    return w;
  endfunction

endpackage

// ----- sv/fcce_ram.sv -----
// Generic single-port RAM with registered read.
module fcce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/framed_config_command_engine_unit.sv -----
// Top level of the framed config command engine: frame parser, setting store, answer sender.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata = rx_byte, tuser = kind
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata = tx_byte, tlast = last, tuser = finished
//
// A byte that causes no answer leaves s_axis ready for the next byte. A byte that closes a frame is
// answered from the next cycle on, 2 to 4 bytes at one per cycle while m_axis is
// ready; the next input is taken in the cycle of the last answer byte, as there is
// a single answer register, fed with read data by the store's read port.
// Reset: store entries read as their defaults until first written (valid bits).
// A stalled m_axis holds the answer and s_axis stays not ready.
module framed_config_command_engine_unit #(
  parameter int unsigned MaxFrame = fcce_pkg::MaxFrame,
  parameter int unsigned NumVars  = fcce_pkg::NumVars
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0] s_axis_tuser,   // [0] kind
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast,
  output logic [0:0] m_axis_tuser    // [0] finished
);

  localparam int unsigned Aw = fcce_pkg::StoreAw;
  localparam int unsigned Dw = fcce_pkg::StoreW;
  localparam int unsigned Nd = fcce_pkg::StoreDepth;
  localparam int unsigned Nh = fcce_pkg::HeadBytes;

  fcce_pkg::phase_e phase_q, phase_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [3:0]  flen_q, flen_d;
  logic [7:0]  fb_q [Nh];
  logic [7:0]  fb_eff [Nh];
  logic [3:0]  flen_eff;
  logic [Nd-1:0] vld_q, vld_d;

  logic        rsp_valid_q, rsp_valid_d;
  logic [1:0]  rsp_pos_q, rsp_pos_d;
  logic [7:0]  rsp_code_q, rsp_code_d;
  logic [1:0]  rsp_w_q, rsp_w_d;
  logic        rsp_fin_q, rsp_fin_d;
  logic [Aw-1:0] rsp_idx_q, rsp_idx_d;
  logic        rsp_dvld_q, rsp_dvld_d;
  logic        rsp_load;

  logic          ram_en, ram_we;
  logic [Aw-1:0] ram_addr;
  logic [Dw-1:0] ram_wdata, ram_rdata, rd_data;

  logic       acc, out_hs, rsp_done;
  logic [7:0] b, cmd;
  logic [3:0] idx;
  logic [1:0] w;
  logic       bad_var;

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign out_hs   = m_axis_tvalid && m_axis_tready;
  assign rsp_done = out_hs && (rsp_pos_q == rsp_w_q + 2'd1);
  assign s_axis_tready = !rsp_valid_q || rsp_done;
  assign b = s_axis_tdata;

  // frame head bytes including the byte in flight
  always_comb begin
    for (int i = 0; i < Nh; i++) begin
      fb_eff[i] = (flen_q == 4'(i)) ? b : fb_q[i];
    end
    flen_eff = ({28'd0, flen_q} < MaxFrame) ? flen_q + 4'd1 : flen_q;
  end

  assign cmd     = fb_eff[0];
  assign idx     = cmd[3:0];
  assign w       = fcce_pkg::var_width(idx);
  assign bad_var = {1'b0, idx} >= 5'(NumVars);

  always_comb begin
    phase_d      = phase_q;
    bytes_left_d = bytes_left_q;
    flen_d       = flen_q;
    vld_d        = vld_q;
    rsp_load     = 1'b0;
    rsp_code_d   = rsp_code_q;
    rsp_w_d      = 2'd0;
    rsp_fin_d    = 1'b0;
    rsp_idx_d    = rsp_idx_q;
    rsp_dvld_d   = rsp_dvld_q;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = idx[Aw-1:0];
    ram_wdata    = {(w == 2'd2) ? fb_eff[2] : 8'h00, fb_eff[1]};

    if (acc) begin
      case (phase_q)
        fcce_pkg::PhWait: begin
          if (!s_axis_tuser[0]) begin
            flen_d = 4'd0;
            if (b > 8'(MaxFrame)) begin
              bytes_left_d = b;
              phase_d      = fcce_pkg::PhDrain;
            end else if (b == 8'd0) begin
              rsp_load   = 1'b1;
              rsp_code_d = fcce_pkg::CodeBadCmd;
            end else begin
              bytes_left_d = b;
              phase_d      = fcce_pkg::PhCollect;
            end
          end
        end
        fcce_pkg::PhDrain: begin
          if (!s_axis_tuser[0]) begin
            bytes_left_d = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : 8'd0;
            if (bytes_left_d == 8'd0) begin
              phase_d    = fcce_pkg::PhWait;
              rsp_load   = 1'b1;
              rsp_code_d = fcce_pkg::CodeTooLong;
            end
          end
        end
        fcce_pkg::PhCollect: begin
          if (s_axis_tuser[0]) begin
            phase_d      = fcce_pkg::PhWait;
            bytes_left_d = 8'd0;
            flen_d       = 4'd0;
            rsp_load     = 1'b1;
            rsp_code_d   = fcce_pkg::CodeTimeout;
          end else begin
            flen_d       = flen_eff;
            bytes_left_d = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : 8'd0;
            if (bytes_left_d == 8'd0) begin
              // frame complete: run the command
              phase_d  = fcce_pkg::PhWait;
              flen_d   = 4'd0;
              rsp_load = 1'b1;
              if (cmd[7:4] == fcce_pkg::OpRead) begin
                if (bad_var) begin
                  rsp_code_d = fcce_pkg::CodeBadVar;
                end else begin
                  rsp_code_d = fcce_pkg::CodeAck;
                  rsp_w_d    = w;
                  rsp_idx_d  = idx[Aw-1:0];
                  if (w != 2'd0) begin
                    ram_en     = 1'b1;
                    rsp_dvld_d = vld_q[idx[Aw-1:0]];
                  end
                end
              end else if (cmd[7:4] == fcce_pkg::OpWrite) begin
                if (bad_var) begin
                  rsp_code_d = fcce_pkg::CodeBadVar;
                end else if (flen_eff < {2'd0, w} + 4'd1) begin
                  rsp_code_d = fcce_pkg::CodeBadParam;
                end else begin
                  rsp_code_d = fcce_pkg::CodeAck;
                  if (w != 2'd0) begin
                    ram_en = 1'b1;
                    ram_we = 1'b1;
                    vld_d[idx[Aw-1:0]] = 1'b1;
                  end
                end
              end else if (cmd == fcce_pkg::CmdFinish) begin
                phase_d    = fcce_pkg::PhDone;
                rsp_code_d = fcce_pkg::CodeAck;
                rsp_fin_d  = 1'b1;
              end else begin
                rsp_code_d = fcce_pkg::CodeBadCmd;
              end
            end
          end
        end
        fcce_pkg::PhDone: begin
        end
        default: begin
          phase_d = fcce_pkg::PhWait;
        end
      endcase
    end

    if (rsp_load) begin
      rsp_valid_d = 1'b1;
      rsp_pos_d   = 2'd0;
    end else begin
      rsp_valid_d = rsp_valid_q && !rsp_done;
      rsp_pos_d   = out_hs ? rsp_pos_q + 2'd1 : rsp_pos_q;
    end
    if (!rsp_load) begin
      rsp_w_d   = rsp_w_q;
      rsp_fin_d = rsp_fin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= fcce_pkg::PhWait;
      bytes_left_q <= 8'd0;
      flen_q       <= 4'd0;
      vld_q        <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_pos_q    <= 2'd0;
    end else begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
      flen_q       <= flen_d;
      vld_q        <= vld_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_pos_q    <= rsp_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_code_q <= rsp_code_d;
    rsp_w_q    <= rsp_w_d;
    rsp_fin_q  <= rsp_fin_d;
    rsp_idx_q  <= rsp_idx_d;
    rsp_dvld_q <= rsp_dvld_d;
    if (acc && phase_q == fcce_pkg::PhCollect && !s_axis_tuser[0]) begin
      for (int i = 0; i < Nh; i++) begin
        if (flen_q == 4'(i)) fb_q[i] <= b;
      end
    end
  end

  fcce_ram #(
    .WIDTH(Dw),
    .DEPTH(Nd)
  ) u_store (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign rd_data = rsp_dvld_q ? ram_rdata : fcce_pkg::store_default(rsp_idx_q);

  always_comb begin
    case (rsp_pos_q)
      2'd0:    m_axis_tdata = {6'd0, rsp_w_q} + 8'd1;
      2'd1:    m_axis_tdata = rsp_code_q;
      2'd2:    m_axis_tdata = rd_data[7:0];
      default: m_axis_tdata = rd_data[15:8];
    endcase
  end

  assign m_axis_tvalid   = rsp_valid_q;
  assign m_axis_tlast    = (rsp_pos_q == rsp_w_q + 2'd1);
  assign m_axis_tuser[0] = rsp_fin_q;

endmodule
